// File: rtl/trpd_pkg.sv
`timescale 1ns / 1ps

package trpd_pkg;

  // Width of the pixel countdown.
  localparam int PIXEL_COUNT_BITS = 30;

  // Configuration register widths.
  localparam int BPP_W   = 3;
  localparam int TOTAL_W = 30;
  localparam int CFG_W   = 30;
  localparam int IDX_W   = 2;

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    REG_BYTES_PER_PIXEL = 2'd0,
    REG_RLE_MODE        = 2'd1,
    REG_PIXEL_TOTAL     = 2'd2
  } cfg_reg_t;

  // Packet byte layout.
  localparam logic [7:0] PKT_RUN_FLAG  = 8'h80;
  localparam logic [6:0] PKT_COUNT_MAX = 7'd127;

  // Stream payload widths.
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 1;

  // One decoded run descriptor.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] repeat_count;
    logic       run_clamped;
    logic       image_done;
  } pixel_run_t;

endpackage

// File: rtl/tga_rle_pixel_decoder_top.sv
`timescale 1ns / 1ps

// Channel   | Signals                         | Contents
// ----------+---------------------------------+-----------------------------------------
// s_axis    | tvalid, tready, tdata[7:0]      | one byte of TGA pixel data
// m_axis    | tvalid, tready, tdata, tuser,   | tdata: red, green, blue, alpha,
//           | tlast                           | repeat_count; tuser: run_clamped;
//           |                                 | tlast: image_done
// cfg       | cfg_we, cfg_index, cfg_data     | 0 bytes_per_pixel, 1 rle_mode, 2 pixel_total
//
// One byte is taken every cycle while tready is high; a result, if any, is registered
// in the output register, or the skid register while that is held. The rate is set
// by the single decode step between the byte and the result. The two-entry output
// keeps taking bytes while one result waits; tready drops only when both are full.
// Reset is synchronous; a write to register 0, 1 or 2 restarts decoding of the image.

module tga_rle_pixel_decoder_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [7:0]                            s_axis_tdata,  // [7:0] in_byte
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [39:32] repeat_count
  output logic [trpd_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  output logic [trpd_pkg::OUT_USER_W-1:0]       m_axis_tuser,  // [0] run_clamped
  output logic                                  m_axis_tlast,
  input  logic                                  cfg_we,
  input  logic [trpd_pkg::IDX_W-1:0]            cfg_index,
  input  logic [trpd_pkg::CFG_W-1:0]            cfg_data
);

  localparam int PIX_W = trpd_pkg::PIXEL_COUNT_BITS;

  // Configuration registers.
  logic [trpd_pkg::BPP_W-1:0]   bytes_per_pixel;
  logic                         rle_mode;
  logic [trpd_pkg::TOTAL_W-1:0] pixel_total;

  // Decoder state.
  logic             expect_packet_byte, expect_packet_byte_next;
  logic             run_packet, run_packet_next;
  logic [7:0]       packet_pixels_left, packet_pixels_left_next;
  logic [1:0]       byte_in_pixel, byte_in_pixel_next;
  logic [23:0]      pixel_bytes, pixel_bytes_next;
  logic [PIX_W-1:0] pixels_left, pixels_left_next;

  // Output register and skid register.
  trpd_pkg::pixel_run_t out_reg, skid_reg, res;
  logic                 out_valid, skid_valid, res_valid;

  logic             accept;
  logic             bpp4;
  logic [1:0]       bip_inc;
  logic             pixel_done;
  logic [23:0]      pb_merged;
  logic [7:0]       repeat_cnt;
  logic             clamped;
  logic [PIX_W-1:0] restart_count;
  logic             cfg_hit;
  logic             out_free;

  assign s_axis_tready = !skid_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign bpp4          = bytes_per_pixel[2];

  // Decode one byte against the current packet and pixel state.
  always_comb begin
    expect_packet_byte_next = expect_packet_byte;
    run_packet_next         = run_packet;
    packet_pixels_left_next = packet_pixels_left;
    byte_in_pixel_next      = byte_in_pixel;
    pixel_bytes_next        = pixel_bytes;
    pixels_left_next        = pixels_left;
    res_valid               = 1'b0;
    repeat_cnt              = 8'd1;
    clamped                 = 1'b0;
    bip_inc                 = byte_in_pixel + 2'd1;
    pixel_done              = bpp4 ? (bip_inc == 2'd0) : (bip_inc == 2'd3);

    // Merge the byte into the BGR word; a fourth byte is alpha only.
    pb_merged = pixel_bytes;
    case (byte_in_pixel)
      2'd0:    pb_merged[7:0]   = s_axis_tdata;
      2'd1:    pb_merged[15:8]  = s_axis_tdata;
      2'd2:    pb_merged[23:16] = s_axis_tdata;
      default: pb_merged = pixel_bytes;
    endcase

    if (accept && (pixels_left != '0)) begin
      if (rle_mode && expect_packet_byte) begin
        // Packet header byte.
        run_packet_next         = (s_axis_tdata & trpd_pkg::PKT_RUN_FLAG) != 8'd0;
        packet_pixels_left_next = {1'b0, s_axis_tdata[6:0] & trpd_pkg::PKT_COUNT_MAX} + 8'd1;
        expect_packet_byte_next = 1'b0;
        byte_in_pixel_next      = 2'd0;
        pixel_bytes_next        = 24'd0;
      end else if (!pixel_done) begin
        byte_in_pixel_next = bip_inc;
        pixel_bytes_next   = pb_merged;
      end else begin
        // Pixel complete: work out its repeat count.
        if (rle_mode) begin
          if (run_packet) begin
            if (PIX_W'(packet_pixels_left) > pixels_left) begin
              repeat_cnt = pixels_left[7:0];
              clamped    = 1'b1;
            end else begin
              repeat_cnt = packet_pixels_left;
            end
            packet_pixels_left_next = 8'd0;
            expect_packet_byte_next = 1'b1;
          end else begin
            clamped = (pixels_left == PIX_W'(1)) && (packet_pixels_left > 8'd1);
            packet_pixels_left_next = packet_pixels_left - 8'd1;
            if (packet_pixels_left == 8'd1) begin
              expect_packet_byte_next = 1'b1;
            end
          end
        end
        pixels_left_next   = pixels_left - PIX_W'(repeat_cnt);
        byte_in_pixel_next = 2'd0;
        pixel_bytes_next   = 24'd0;
        res_valid          = 1'b1;
      end
    end

    res.red          = pb_merged[23:16];
    res.green        = pb_merged[15:8];
    res.blue         = pb_merged[7:0];
    res.alpha        = bpp4 ? s_axis_tdata : 8'd0;
    res.repeat_count = repeat_cnt;
    res.run_clamped  = clamped;
    res.image_done   = (pixels_left_next == '0);
  end

  // Configuration decode; the countdown reloads from the newest total.
  always_comb begin
    cfg_hit       = 1'b0;
    restart_count = PIX_W'(pixel_total);
    if (cfg_we) begin
      unique case (cfg_index)
        trpd_pkg::REG_BYTES_PER_PIXEL: cfg_hit = 1'b1;
        trpd_pkg::REG_RLE_MODE:        cfg_hit = 1'b1;
        trpd_pkg::REG_PIXEL_TOTAL: begin
          cfg_hit       = 1'b1;
          restart_count = PIX_W'(cfg_data);
        end
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  // Configuration registers and decoder state.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_pixel    <= 3'd4;
      rle_mode           <= 1'b1;
      pixel_total        <= '0;
      expect_packet_byte <= 1'b1;
      run_packet         <= 1'b0;
      packet_pixels_left <= 8'd0;
      byte_in_pixel      <= 2'd0;
      pixel_bytes        <= 24'd0;
      pixels_left        <= '0;
    end else if (cfg_hit) begin
      if (cfg_index == trpd_pkg::REG_BYTES_PER_PIXEL) begin
        bytes_per_pixel <= cfg_data[trpd_pkg::BPP_W-1:0];
      end
      if (cfg_index == trpd_pkg::REG_RLE_MODE) begin
        rle_mode <= cfg_data[0];
      end
      if (cfg_index == trpd_pkg::REG_PIXEL_TOTAL) begin
        pixel_total <= cfg_data[trpd_pkg::TOTAL_W-1:0];
      end
      expect_packet_byte <= 1'b1;
      run_packet         <= 1'b0;
      packet_pixels_left <= 8'd0;
      byte_in_pixel      <= 2'd0;
      pixel_bytes        <= 24'd0;
      pixels_left        <= restart_count;
    end else begin
      expect_packet_byte <= expect_packet_byte_next;
      run_packet         <= run_packet_next;
      packet_pixels_left <= packet_pixels_left_next;
      byte_in_pixel      <= byte_in_pixel_next;
      pixel_bytes        <= pixel_bytes_next;
      pixels_left        <= pixels_left_next;
    end
  end

  // Output register with a skid entry behind it.
  assign out_free = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_reg <= skid_valid ? skid_reg : res;
    end else if (res_valid) begin
      skid_reg <= res;
    end
  end

  // Result transfer fields.
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_reg.repeat_count, out_reg.alpha, out_reg.blue,
                          out_reg.green, out_reg.red};
  assign m_axis_tuser  = out_reg.run_clamped;
  assign m_axis_tlast  = out_reg.image_done;

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

// Tracks the decoder state byte by byte and holds the run descriptors still owed.
class pixel_run_scoreboard;
  bit [trpd_pkg::BPP_W-1:0]            bpp_reg;
  bit                                  rle_reg;
  bit [trpd_pkg::TOTAL_W-1:0]          total_reg;
  bit                                  want_header;
  bit                                  run_pkt;
  bit [7:0]                            pkt_left;
  bit [1:0]                            byte_idx;
  bit [23:0]                           bgr_acc;
  bit [trpd_pkg::PIXEL_COUNT_BITS-1:0] pixels_left;
  trpd_pkg::pixel_run_t                owed_runs[$];
  int unsigned                         errors;

  function new();
    bpp_reg   = 3'd4;
    rle_reg   = 1'b1;
    total_reg = '0;
    errors    = 0;
    restart();
  endfunction

  // Any write to a real register starts the image over.
  function void restart();
    want_header = 1'b1;
    run_pkt     = 1'b0;
    pkt_left    = '0;
    byte_idx    = '0;
    bgr_acc     = '0;
    pixels_left = trpd_pkg::PIXEL_COUNT_BITS'(total_reg);
  endfunction

  function void apply_write(bit [trpd_pkg::IDX_W-1:0] idx, bit [trpd_pkg::CFG_W-1:0] d);
    case (idx)
      trpd_pkg::REG_BYTES_PER_PIXEL: bpp_reg = d[trpd_pkg::BPP_W-1:0];
      trpd_pkg::REG_RLE_MODE:        rle_reg = d[0];
      trpd_pkg::REG_PIXEL_TOTAL:     total_reg = d[trpd_pkg::TOTAL_W-1:0];
      default:                       return;
    endcase
    restart();
  endfunction

  function int unsigned pending();
    return owed_runs.size();
  endfunction

  // Returns 1 when the byte was taken into the image, 0 when it was dropped.
  function bit note_byte(bit [7:0] b);
    int unsigned          width_b;
    trpd_pkg::pixel_run_t r;
    bit [7:0]             rep;
    bit                   clip;
    width_b = (bpp_reg >= 4) ? 4 : 3;
    if (pixels_left == 0) return 1'b0;

    // Packet header: bit 7 picks a run, the low bits give the pixel count less one.
    if (rle_reg && want_header) begin
      run_pkt     = b[7];
      pkt_left    = {1'b0, b[6:0]} + 8'd1;
      want_header = 1'b0;
      byte_idx    = '0;
      bgr_acc     = '0;
      return 1'b1;
    end

    // Gather B, G, R; a fourth byte is alpha and is not stored.
    if (byte_idx < 3) bgr_acc |= 24'(b) << (8 * byte_idx);
    byte_idx = byte_idx + 2'd1;
    if (byte_idx < width_b && byte_idx != 0) return 1'b1;

    r.alpha  = (width_b == 4) ? b : 8'd0;
    byte_idx = '0;
    rep      = 8'd1;
    clip     = 1'b0;
    if (rle_reg) begin
      if (run_pkt) begin
        rep = pkt_left;
        if (rep > pixels_left) begin
          rep  = 8'(pixels_left);
          clip = 1'b1;
        end
        pkt_left    = '0;
        want_header = 1'b1;
      end else begin
        // A literal packet that still promises pixels when the image ends.
        if (pixels_left == 1 && pkt_left > 1) clip = 1'b1;
        pkt_left = pkt_left - 8'd1;
        if (pkt_left == 0) want_header = 1'b1;
      end
    end
    pixels_left    = pixels_left - rep;
    r.red          = bgr_acc[23:16];
    r.green        = bgr_acc[15:8];
    r.blue         = bgr_acc[7:0];
    r.repeat_count = rep;
    r.run_clamped  = clip;
    r.image_done   = (pixels_left == 0);
    bgr_acc        = '0;
    owed_runs.push_back(r);
    return 1'b1;
  endfunction

  task report(string what);
    errors++;
    if (errors <= 60) $display("MISMATCH: %s", what);
  endtask

  task check_run(logic [trpd_pkg::OUT_DATA_W-1:0] data,
                 logic [trpd_pkg::OUT_USER_W-1:0] user, logic last);
    trpd_pkg::pixel_run_t want;
    if (owed_runs.size() == 0) begin
      report($sformatf("run descriptor with none owed: tdata=%h", data));
      return;
    end
    want = owed_runs.pop_front();
    if (data[7:0] !== want.red)
      report($sformatf("red %h, want %h", data[7:0], want.red));
    if (data[15:8] !== want.green)
      report($sformatf("green %h, want %h", data[15:8], want.green));
    if (data[23:16] !== want.blue)
      report($sformatf("blue %h, want %h", data[23:16], want.blue));
    if (data[31:24] !== want.alpha)
      report($sformatf("alpha %h, want %h", data[31:24], want.alpha));
    if (data[39:32] !== want.repeat_count)
      report($sformatf("repeat_count %0d, want %0d", data[39:32], want.repeat_count));
    if (user[0] !== want.run_clamped)
      report($sformatf("run_clamped %b, want %b", user[0], want.run_clamped));
    if (last !== want.image_done)
      report($sformatf("image_done %b, want %b", last, want.image_done));
  endtask
endclass

module tb;

  localparam logic [trpd_pkg::IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int unsigned ITEM_TARGET = 1100;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam longint unsigned CYCLE_LIMIT = 1000000;

  logic                            clk;
  logic                            rst;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [7:0]                      s_axis_tdata;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [trpd_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [trpd_pkg::OUT_USER_W-1:0] m_axis_tuser;
  logic                            m_axis_tlast;
  logic                            cfg_we;
  logic [trpd_pkg::IDX_W-1:0]      cfg_index;
  logic [trpd_pkg::CFG_W-1:0]      cfg_data;

  pixel_run_scoreboard sb;
  bit                  calm;
  bit                  long_hold_req;
  int unsigned         bytes_used;
  longint unsigned     cycle_count;

  tga_rle_pixel_decoder_top uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int unsigned pick_gap();
    if (calm) return 0;
    if ($urandom_range(99) < 70) return 0;
    if ($urandom_range(99) < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Output side: random stalls, plus one long hold-off when asked.
  initial begin
    int unsigned stall;
    stall = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall = LONG_HOLD_CYCLES;
      end else if (stall == 0) begin
        stall = pick_gap();
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Check every transfer on the output side.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_run(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offer one byte after a random gap and wait for its transfer.
  task automatic feed_byte(input bit [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (sb.note_byte(b)) bytes_used++;
    @(negedge clk);
  endtask

  task automatic feed_pixel(input int unsigned width_b);
    repeat (width_b) feed_byte(8'($urandom));
  endtask

  // Write one register; the caller lowers cfg_we after its last write.
  task automatic cfg_write(input logic [trpd_pkg::IDX_W-1:0] idx,
                           input logic [trpd_pkg::CFG_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    sb.apply_write(idx, d);
    @(negedge clk);
  endtask

  // Unused upper data bits carry random values to show they are masked.
  task automatic program_image(input bit [2:0] bpp_v, input bit rle_v,
                               input bit [trpd_pkg::TOTAL_W-1:0] total_v);
    logic [trpd_pkg::CFG_W-1:0] d;
    d = trpd_pkg::CFG_W'($urandom);
    d[trpd_pkg::BPP_W-1:0] = bpp_v;
    cfg_write(trpd_pkg::REG_BYTES_PER_PIXEL, d);
    d = trpd_pkg::CFG_W'($urandom);
    d[0] = rle_v;
    cfg_write(trpd_pkg::REG_RLE_MODE, d);
    cfg_write(trpd_pkg::REG_PIXEL_TOTAL, trpd_pkg::CFG_W'(total_v));
    cfg_we <= 1'b0;
  endtask

  // Wait until every owed result is out and the pipeline has settled.
  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic end_phase();
    s_axis_tvalid <= 1'b0;
    wait_idle();
  endtask

  // One image with random settings: mostly well-formed packets, some noise.
  task automatic feed_random_image();
    bit [2:0]                   bpp_v;
    bit                         rle_v;
    bit [trpd_pkg::TOTAL_W-1:0] total_v;
    bit                         is_run;
    int unsigned                width_b;
    int unsigned                goal;
    int unsigned                made;
    int unsigned                n;
    bpp_v = 3'($urandom);
    rle_v = 1'($urandom);
    case ($urandom_range(9))
      0:       total_v = '0;
      1:       total_v = trpd_pkg::TOTAL_W'($urandom);
      default: total_v = trpd_pkg::TOTAL_W'($urandom_range(24, 1));
    endcase
    calm = ($urandom_range(3) == 0);
    if ($urandom_range(3) == 0) begin
      cfg_write(REG_SPARE, trpd_pkg::CFG_W'($urandom));
    end
    program_image(bpp_v, rle_v, total_v);
    width_b = (bpp_v >= 4) ? 4 : 3;
    goal = (total_v > 40) ? $urandom_range(40, 10) : 32'(total_v);

    if (total_v == 0 || $urandom_range(6) == 0) begin
      // Unstructured bytes.
      repeat ($urandom_range(60, 10)) feed_byte(8'($urandom));
    end else begin
      made = 0;
      while (made < goal) begin
        if (rle_v) begin
          is_run = 1'($urandom);
          n = ($urandom_range(4) == 0) ? $urandom_range(128, 1) : $urandom_range(8, 1);
          feed_byte({is_run, 7'(n - 1)});
          if (is_run) begin
            feed_pixel(width_b);
            made += n;
          end else begin
            for (int unsigned i = 0; i < n && made < goal; i++) begin
              feed_pixel(width_b);
              made++;
            end
          end
        end else begin
          feed_pixel(width_b);
          made++;
        end
        // A stray byte now and then knocks the stream out of step.
        if ($urandom_range(49) == 0) feed_byte(8'($urandom));
      end
      // Bytes past the end of the image.
      repeat ($urandom_range(3)) feed_byte(8'($urandom));
    end
    end_phase();
  endtask

  // Main sequence.
  initial begin
    sb = new();
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    calm = 1'b0;
    long_hold_req = 1'b0;
    bytes_used = 0;
    cycle_count = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // After reset the image is empty, so the byte is dropped.
    feed_byte(8'hFF);
    end_phase();

    // Reset pixel size: a run of one, then a run of 128 cut to the two pixels left.
    cfg_write(trpd_pkg::REG_PIXEL_TOTAL, trpd_pkg::CFG_W'(3));
    cfg_we <= 1'b0;
    feed_byte(8'h80);
    feed_byte(8'h00); feed_byte(8'hFF); feed_byte(8'hA5); feed_byte(8'h5A);
    feed_byte(8'hFF);
    feed_byte(8'hFF); feed_byte(8'h00); feed_byte(8'h5A); feed_byte(8'hA5);
    end_phase();

    // 24-bit literal packet promising 128 pixels, cut when the image ends.
    program_image(3'd3, 1'b1, trpd_pkg::TOTAL_W'(2));
    feed_byte(8'h7F);
    feed_byte(8'h00); feed_byte(8'h00); feed_byte(8'h00);
    feed_byte(8'hFF); feed_byte(8'hFF); feed_byte(8'hFF);
    end_phase();

    // Raw mode with pixel size 0 (acts as 3); a spare-index write mid-image changes nothing.
    program_image(3'd0, 1'b0, trpd_pkg::TOTAL_W'(2));
    feed_byte(8'h01); feed_byte(8'h02); feed_byte(8'h03);
    end_phase();
    cfg_write(REG_SPARE, '1);
    cfg_we <= 1'b0;
    feed_byte(8'h10); feed_byte(8'h20); feed_byte(8'h30);
    end_phase();

    // Raw mode, pixel size 7 (acts as 4), largest pixel total.
    program_image(3'd7, 1'b0, '1);
    feed_byte(8'h00); feed_byte(8'hFF); feed_byte(8'h80); feed_byte(8'h7F);
    end_phase();

    // Long output hold-off while bytes keep coming, so the input stalls.
    calm = 1'b1;
    program_image(3'd3, 1'b0, trpd_pkg::TOTAL_W'(80));
    long_hold_req = 1'b1;
    repeat (240) feed_byte(8'($urandom));
    end_phase();

    while (bytes_used < ITEM_TARGET) feed_random_image();

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/trpd_pkg.sv
rtl/tga_rle_pixel_decoder_top.sv
verif/tb.sv
